FILE: design/bole_pkg.sv
// Shared constants for the bounded ordered list engine.
// Holds capacity, derived widths, request and status codes. No dependencies.
`default_nettype none
package bole_pkg;
  localparam int CAPACITY = 16;
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] REQ_INS_HEAD = 3'd0;
  localparam logic [2:0] REQ_INS_TAIL = 3'd1;
  localparam logic [2:0] REQ_INS_POS  = 3'd2;
  localparam logic [2:0] REQ_DEL_HEAD = 3'd3;
  localparam logic [2:0] REQ_DEL_TAIL = 3'd4;
  localparam logic [2:0] REQ_DEL_VAL  = 3'd5;
  localparam logic [2:0] REQ_TRAVERSE = 3'd6;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;
endpackage
`default_nettype wire

FILE: design/bounded_ordered_list_engine_top.sv
// Bounded ordered list engine: list held in one synchronous RAM, shifted
// entry by entry on insert and delete. Depends on bole_pkg.
// Insert and delete move one entry per step; value search compares entries in
// list order; traverse reads elements one at a time through the single RAM
// read port. One request at a time.
// Reset (synchronous, rst_n low) empties the list; RAM contents are not cleared.
`default_nettype none
module bounded_ordered_list_engine_top
  import bole_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [31:0] item_value, [39:32] insert_position
  input  wire logic [2:0]  in_tuser,   // [2:0] req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [31:0] out_value, [36:32] element_count, zero fill
  output logic [1:0]       out_tuser,  // [1:0] status
  output logic             out_tlast
);

  typedef enum logic [3:0] {
    S_IDLE, S_SU, S_SU_W, S_DEL_RD, S_SD_RD, S_SD_WR,
    S_SC_RD, S_SC_CMP, S_TR_RD, S_TR_DAT, S_RESP
  } state_t;

  logic [31:0]   mem [CAPACITY];
  logic [31:0]   rd_q;
  logic [AW-1:0] ra;
  logic          we;
  logic [AW-1:0] wa;
  logic [31:0]   wd;

  state_t        state_r;
  logic [CW-1:0] len_r;
  logic [CW-1:0] i_r;
  logic [CW-1:0] idx_r;
  logic [31:0]   val_r;
  logic [31:0]   v_r;
  logic [1:0]    st_r;
  logic          lst_r;
  logic          trav_r;
  logic          out_valid_r;
  logic [31:0]   out_value_r;
  logic [1:0]    out_status_r;
  logic          out_last_r;
  logic [CW-1:0] out_count_r;

  logic          in_acc;
  logic          out_free;
  logic [2:0]    req;
  logic [7:0]    pos;
  logic [CW-1:0] ins_idx;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign req        = in_tuser;
  assign pos        = in_tdata[39:32];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_count_r, out_value_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  // Insert slot, clamped to the tail.
  always_comb begin
    if (req == REQ_INS_HEAD || pos <= 8'd1) begin
      ins_idx = '0;
    end else if (req == REQ_INS_TAIL || {1'b0, pos} - 9'd1 >= 9'(len_r)) begin
      ins_idx = len_r;
    end else begin
      ins_idx = CW'(pos - 8'd1);
    end
  end

  // RAM port control.
  always_comb begin
    ra = i_r[AW-1:0];
    we = 1'b0;
    wa = i_r[AW-1:0];
    wd = rd_q;
    unique case (state_r)
      S_IDLE: begin
        if (req == REQ_DEL_TAIL) ra = AW'(len_r - CW'(1));
        else ra = '0;
      end
      S_SU: begin
        ra = AW'(i_r - CW'(1));
        if (i_r <= idx_r) begin
          we = 1'b1;
          wa = idx_r[AW-1:0];
          wd = val_r;
        end
      end
      S_SU_W:  we = 1'b1;
      S_SD_RD: ra = AW'(i_r + CW'(1));
      S_SD_WR: we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && state_r != S_RESP) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            val_r  <= in_tdata[31:0];
            trav_r <= (req == REQ_TRAVERSE) && (len_r != '0);
            lst_r  <= 1'b1;
            v_r    <= '0;
            case (req) inside
              REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_POS: begin
                if (len_r >= CW'(CAPACITY)) begin
                  st_r    <= ST_FULL;
                  state_r <= S_RESP;
                end else begin
                  st_r    <= ST_DONE;
                  idx_r   <= ins_idx;
                  i_r     <= len_r;
                  state_r <= S_SU;
                end
              end
              REQ_DEL_HEAD, REQ_DEL_TAIL: begin
                if (len_r == '0) begin
                  st_r    <= ST_EMPTY;
                  state_r <= S_RESP;
                end else begin
                  st_r    <= ST_DONE;
                  i_r     <= (req == REQ_DEL_TAIL) ? len_r - CW'(1) : '0;
                  state_r <= S_DEL_RD;
                end
              end
              REQ_DEL_VAL: begin
                if (len_r == '0) begin
                  st_r    <= ST_EMPTY;
                  state_r <= S_RESP;
                end else begin
                  st_r    <= ST_DONE;
                  i_r     <= '0;
                  state_r <= S_SC_RD;
                end
              end
              REQ_TRAVERSE: begin
                if (len_r == '0) begin
                  st_r    <= ST_EMPTY;
                  state_r <= S_RESP;
                end else begin
                  st_r    <= ST_DONE;
                  i_r     <= '0;
                  state_r <= S_TR_RD;
                end
              end
              default: begin
                st_r    <= ST_DONE;
                state_r <= S_RESP;
              end
            endcase
          end
        end
        S_SU: begin
          if (i_r > idx_r) begin
            state_r <= S_SU_W;
          end else begin
            len_r   <= len_r + CW'(1);
            state_r <= S_RESP;
          end
        end
        S_SU_W: begin
          i_r     <= i_r - CW'(1);
          state_r <= S_SU;
        end
        S_DEL_RD: begin
          v_r     <= rd_q;
          state_r <= S_SD_RD;
        end
        S_SD_RD: begin
          if (i_r + CW'(1) < len_r) begin
            state_r <= S_SD_WR;
          end else begin
            len_r   <= len_r - CW'(1);
            state_r <= S_RESP;
          end
        end
        S_SD_WR: begin
          i_r     <= i_r + CW'(1);
          state_r <= S_SD_RD;
        end
        S_SC_RD: begin
          if (i_r == len_r) begin
            st_r    <= ST_NOT_FOUND;
            state_r <= S_RESP;
          end else begin
            state_r <= S_SC_CMP;
          end
        end
        S_SC_CMP: begin
          if (rd_q == val_r) begin
            v_r     <= rd_q;
            state_r <= S_SD_RD;
          end else begin
            i_r     <= i_r + CW'(1);
            state_r <= S_SC_RD;
          end
        end
        S_TR_RD: state_r <= S_TR_DAT;
        S_TR_DAT: begin
          v_r     <= rd_q;
          lst_r   <= (i_r + CW'(1) == len_r);
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= st_r;
            out_value_r  <= v_r;
            out_last_r   <= lst_r;
            out_count_r  <= len_r;
            if (trav_r && !lst_r) begin
              i_r     <= i_r + CW'(1);
              state_r <= S_TR_RD;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_DONE |-> out_tlast && out_tdata[31:0] == 32'd0)
    else $error("nonzero status must be a single zero-valued result");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[36:32] <= CW'(CAPACITY))
    else $error("element count beyond capacity");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second request taken while busy");
endmodule
`default_nettype wire

FILE: tb/tb_bounded_ordered_list_engine_top.sv
// Testbench for the bounded ordered list engine: directed and random list requests.
// Predicts every result from its own list model and checks each out transaction.
// Depends on bole_pkg and bounded_ordered_list_engine_top.
`timescale 1ns / 1ps
module tb_bounded_ordered_list_engine_top;
  import bole_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [2:0] REQ_RESERVED = 3'd7;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
    logic        last;
    logic [4:0]  count;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [39:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0] out_tuser;
  logic out_tlast;

  logic [31:0] shadow_list[$];
  list_result_t pending_results[$];
  int error_count = 0;
  int results_seen = 0;
  int requests_sent = 0;
  int idle_cycles = 0;

  bounded_ordered_list_engine_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic void push_result(logic [1:0] st, logic [31:0] v, logic lst);
    list_result_t r;
    r.status = st;
    r.value = v;
    r.last = lst;
    r.count = 5'(shadow_list.size());
    pending_results.push_back(r);
  endfunction

  // Apply one request to the shadow list and queue what it should return.
  function automatic void predict_request(logic [2:0] req, logic [31:0] v, logic [7:0] pos);
    int idx;
    int found;
    logic [31:0] taken;
    case (req)
      REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_POS: begin
        if (shadow_list.size() >= CAPACITY) begin
          push_result(ST_FULL, '0, 1'b1);
        end else begin
          if (req == REQ_INS_HEAD || pos <= 1) idx = 0;
          else if (req == REQ_INS_TAIL) idx = shadow_list.size();
          else idx = pos - 1;
          if (idx > shadow_list.size()) idx = shadow_list.size();
          shadow_list.insert(idx, v);
          push_result(ST_DONE, '0, 1'b1);
        end
      end
      REQ_DEL_HEAD, REQ_DEL_TAIL: begin
        if (shadow_list.size() == 0) begin
          push_result(ST_EMPTY, '0, 1'b1);
        end else begin
          taken = (req == REQ_DEL_HEAD) ? shadow_list.pop_front() : shadow_list.pop_back();
          push_result(ST_DONE, taken, 1'b1);
        end
      end
      REQ_DEL_VAL: begin
        if (shadow_list.size() == 0) begin
          push_result(ST_EMPTY, '0, 1'b1);
        end else begin
          found = -1;
          foreach (shadow_list[i]) if (found < 0 && shadow_list[i] == v) found = i;
          if (found < 0) begin
            push_result(ST_NOT_FOUND, '0, 1'b1);
          end else begin
            taken = shadow_list[found];
            shadow_list.delete(found);
            push_result(ST_DONE, taken, 1'b1);
          end
        end
      end
      REQ_TRAVERSE: begin
        if (shadow_list.size() == 0) push_result(ST_EMPTY, '0, 1'b1);
        else foreach (shadow_list[i])
          push_result(ST_DONE, shadow_list[i], i == shadow_list.size() - 1);
      end
      default: push_result(ST_DONE, '0, 1'b1);
    endcase
  endfunction

  // Keep tvalid high across a zero gap so back-to-back requests need no extra edge.
  task automatic send_request(input logic [2:0] req, input logic [31:0] v,
                              input logic [7:0] pos);
    int gap;
    gap = $urandom_range(0, 16);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= req;
    in_tdata <= {pos, v};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_request(req, v, pos);
    requests_sent++;
  endtask

  // Draw a readiness delay per result; hold tready low for that many cycles.
  initial begin
    int stall;
    forever begin
      @(posedge clk);
      if (out_tvalid && !out_tready) begin
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        repeat (stall) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.status)
          report_mismatch($sformatf("status %0d want %0d", out_tuser, want.status));
        if (out_tdata[31:0] !== want.value)
          report_mismatch($sformatf("value %0h want %0h", out_tdata[31:0], want.value));
        if (out_tlast !== want.last)
          report_mismatch($sformatf("last %0b want %0b", out_tlast, want.last));
        if (out_tdata[36:32] !== want.count)
          report_mismatch($sformatf("count %0d want %0d", out_tdata[36:32], want.count));
      end
    end
  end

  // Count cycles without any transaction; stop the run when stuck.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'($urandom_range(0, 7));
      default: return $urandom();
    endcase
  endfunction

  // Pick a value already in the list so deletes by value usually hit.
  function automatic logic [31:0] pick_present();
    if (shadow_list.size() == 0 || $urandom_range(0, 3) == 0) return pick_value();
    return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
  endfunction

  task automatic test_empty_list();
    send_request(REQ_DEL_HEAD, '0, 8'd0);
    send_request(REQ_DEL_TAIL, '0, 8'd0);
    send_request(REQ_DEL_VAL, 32'h1234, 8'd0);
    send_request(REQ_TRAVERSE, '0, 8'd0);
    send_request(REQ_INS_POS, 32'h8000_0000, 8'd200);
    send_request(REQ_DEL_TAIL, '0, 8'd0);
    send_request(REQ_RESERVED, 32'hFFFF_FFFF, 8'hFF);
  endtask

  task automatic test_inserts_and_positions();
    send_request(REQ_INS_HEAD, 32'h7FFF_FFFF, 8'd0);
    send_request(REQ_INS_TAIL, 32'h8000_0000, 8'd0);
    send_request(REQ_INS_POS, 32'h0000_0005, 8'd0);
    send_request(REQ_INS_POS, 32'h0000_0006, 8'd1);
    send_request(REQ_INS_POS, 32'h0000_0007, 8'd3);
    send_request(REQ_INS_POS, 32'hFFFF_FFFF, 8'd255);
    send_request(REQ_TRAVERSE, '0, 8'd0);
    send_request(REQ_DEL_VAL, 32'h0000_0099, 8'd0);
    send_request(REQ_DEL_VAL, 32'h0000_0007, 8'd0);
    send_request(REQ_DEL_HEAD, '0, 8'd0);
  endtask

  task automatic test_full_list();
    while (shadow_list.size() < CAPACITY)
      send_request(REQ_INS_TAIL, 32'(shadow_list.size()), 8'd0);
    send_request(REQ_INS_HEAD, 32'h1, 8'd0);
    send_request(REQ_INS_POS, 32'h2, 8'd4);
    send_request(REQ_TRAVERSE, '0, 8'd0);
  endtask

  task automatic test_random_requests(input int n);
    logic [2:0] req;
    logic [7:0] pos;
    repeat (n) begin
      req = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 15) == 0) req = REQ_RESERVED;
      else if (req == REQ_RESERVED) req = REQ_INS_POS;
      pos = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 18)) : 8'($urandom());
      send_request(req, (req == REQ_DEL_VAL) ? pick_present() : pick_value(), pos);
    end
  endtask

  initial begin
    int drain;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_list();
    test_inserts_and_positions();
    test_full_list();
    test_random_requests(400);
    in_tvalid <= 1'b0;
    drain = 0;
    while (pending_results.size() != 0 && drain < WATCHDOG_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (100) @(posedge clk);
    $display("covered %0d requests and %0d results across all request kinds",
             requests_sent, results_seen);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
